### rtl/apid_pkg.sv
package apid_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int SUM_BITS   = 32;
  localparam int IN_W       = 16;
  localparam int GAIN_W     = 16;
  localparam int DRIVE_W    = 32;
  localparam int FRAC_BITS  = 8;

  localparam int DE_W       = ANGLE_BITS + 1;
  localparam int PROD_MAX_W = GAIN_W + ((DE_W > SUM_BITS) ? DE_W : SUM_BITS);
  localparam int ACC_MIN_W  = PROD_MAX_W + 2;
  localparam int ACC_W      = (ACC_MIN_W > DRIVE_W + FRAC_BITS + 1) ?
                              ACC_MIN_W : (DRIVE_W + FRAC_BITS + 1);
  localparam int SH_W       = ACC_W - FRAC_BITS;
  localparam int SUMX_W     = ((SUM_BITS > ANGLE_BITS) ? SUM_BITS : ANGLE_BITS) + 1;

  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2
  } reg_idx_t;

endpackage

### rtl/angle_wrapped_pid_step.sv
// PID step on binary angles (a full turn is 2^16 units). Each input word carries a measured
// and a target angle; the error wraps to the signed half-turn range, and drive =
// floor((Kp*e + Kd*(e - previous e) + Ki*sum) / 256), saturated to 32 bits, where sum is the
// error sum from before this word. The sum then takes e, saturating at 32 bits. Gains are
// signed Q8.8 and reset to zero; write them only while the block is idle. A word is held in
// the input register, then the three multipliers, the adder and the saturation produce its
// result into the output register; throughput is one word per cycle while the output side
// keeps up.
module angle_wrapped_pid_step
  import apid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // measured_angle [15:0], target_angle [31:16]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // drive [31:0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata
);

  logic signed [GAIN_W-1:0]     gain_p_r, gain_i_r, gain_d_r;
  logic                         s1_valid_r;
  logic [IN_W-1:0]              meas_r, tgt_r;
  logic                         out_valid_r;
  logic signed [DRIVE_W-1:0]    drive_r;
  logic signed [SUM_BITS-1:0]   error_sum_r;
  logic signed [ANGLE_BITS-1:0] prev_err_r;

  logic                                 advance;
  logic                                 step;
  logic signed [ANGLE_BITS-1:0]         err;
  logic signed [DE_W-1:0]               derr;
  logic signed [GAIN_W+ANGLE_BITS-1:0]  prod_p;
  logic signed [GAIN_W+DE_W-1:0]        prod_d;
  logic signed [GAIN_W+SUM_BITS-1:0]    prod_i;
  logic signed [ACC_W-1:0]              acc;
  logic signed [SH_W-1:0]               shifted;
  logic [SH_W-DRIVE_W:0]                drv_top;
  logic signed [DRIVE_W-1:0]            drive_nxt;
  logic signed [SUMX_W-1:0]             sum_wide;
  logic [SUMX_W-SUM_BITS:0]             sum_top;
  logic signed [SUM_BITS-1:0]           error_sum_nxt;

  assign advance    = !out_valid_r || out_tready;
  assign step       = s1_valid_r && advance;
  assign in_tready  = advance || !s1_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = drive_r;

  // error wraps by truncation to the angle width
  assign err  = $signed(ANGLE_BITS'(tgt_r) - ANGLE_BITS'(meas_r));
  assign derr = DE_W'(err) - DE_W'(prev_err_r);

  assign prod_p = (GAIN_W+ANGLE_BITS)'(gain_p_r) * (GAIN_W+ANGLE_BITS)'(err);
  assign prod_d = (GAIN_W+DE_W)'(gain_d_r) * (GAIN_W+DE_W)'(derr);
  assign prod_i = (GAIN_W+SUM_BITS)'(gain_i_r) * (GAIN_W+SUM_BITS)'(error_sum_r);

  assign acc = ACC_W'(prod_p) + ACC_W'(prod_d) + ACC_W'(prod_i);

  assign shifted = SH_W'(acc >>> FRAC_BITS);
  assign drv_top = shifted[SH_W-1:DRIVE_W-1];

  always_comb begin
    if (&drv_top || ~|drv_top) begin
      drive_nxt = shifted[DRIVE_W-1:0];
    end else if (shifted[SH_W-1]) begin
      drive_nxt = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_nxt = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  assign sum_wide = SUMX_W'(error_sum_r) + SUMX_W'(err);
  assign sum_top  = sum_wide[SUMX_W-1:SUM_BITS-1];

  always_comb begin
    if (&sum_top || ~|sum_top) begin
      error_sum_nxt = sum_wide[SUM_BITS-1:0];
    end else if (sum_wide[SUMX_W-1]) begin
      error_sum_nxt = {1'b1, {(SUM_BITS-1){1'b0}}};
    end else begin
      error_sum_nxt = {1'b0, {(SUM_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      error_sum_r <= '0;
      prev_err_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN_P: gain_p_r <= cfg_wdata;
          REG_GAIN_I: gain_i_r <= cfg_wdata;
          REG_GAIN_D: gain_d_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        error_sum_r <= error_sum_nxt;
        prev_err_r  <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      meas_r <= in_tdata[IN_W-1:0];
      tgt_r  <= in_tdata[2*IN_W-1:IN_W];
    end
    if (step) begin
      drive_r <= drive_nxt;
    end
  end

  // state moves only with a word passing to the output register
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(error_sum_r) && $stable(prev_err_r))
    else $error("error sum changed without a word");

  a_prev_err: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> prev_err_r == $past(err))
    else $error("previous error not taken from the last word");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result shown without a word in the input register");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty output register");

endmodule
